@@ hdl/sdspi_pkg.sv @@
package sdspi_pkg;

	localparam int BLOCK_BYTES = 512;
	localparam int BLOCK_AW = $clog2(BLOCK_BYTES);
	localparam int POWERUP_DUMMY_BYTES = 10;
	localparam int CNT_W = 10;

	localparam logic [7:0] FILL_BYTE = 8'hFF;
	localparam logic [7:0] START_TOKEN = 8'hFE;
	localparam logic [7:0] CMD_PREFIX = 8'h40;
	localparam logic [7:0] CRC_CMD0 = 8'h95;
	localparam logic [7:0] CRC_CMD8 = 8'h87;
	localparam logic [7:0] CRC_OTHER = 8'h01;
	localparam logic [11:0] CHECK_PATTERN = 12'h1AA;
	localparam logic [31:0] ARG_CMD8 = 32'h0000_01AA;
	localparam logic [31:0] ARG_ACMD41 = 32'h4000_0000;
	localparam int OCR_CCS_BIT = 30;

	localparam logic [5:0] CMD_GO_IDLE = 6'd0;
	localparam logic [5:0] CMD_SEND_IF_COND = 6'd8;
	localparam logic [5:0] CMD_READ_SINGLE = 6'd17;
	localparam logic [5:0] CMD_SD_SEND_OP = 6'd41;
	localparam logic [5:0] CMD_APP = 6'd55;
	localparam logic [5:0] CMD_READ_OCR = 6'd58;

	typedef enum logic [1:0] {
		OP_INIT   = 2'd0,
		OP_READ   = 2'd1,
		OP_STREAM = 2'd2,
		OP_REPLY  = 2'd3
	} op_t;

	typedef enum logic [3:0] {
		PH_IDLE     = 4'd0,
		PH_POWER    = 4'd1,
		PH_READY    = 4'd2,
		PH_COMMAND  = 4'd3,
		PH_RESPONSE = 4'd4,
		PH_TAIL     = 4'd5,
		PH_TOKEN    = 4'd6,
		PH_DATA     = 4'd7,
		PH_CRC      = 4'd8
	} phase_t;

	typedef struct packed {
		op_t         op;
		logic [31:0] block_or_offset;
		logic [31:0] byte_count;
		logic [7:0]  rx_byte;
	} item_t;

	typedef struct packed {
		logic       tx_valid;
		logic [7:0] tx_byte;
		logic       select_high;
		logic       data_valid;
		logic [7:0] data_byte;
		logic       busy;
		logic       done;
		logic       high_capacity;
		logic       v2_card;
		logic       voltage_ok;
	} result_t;

endpackage

@@ hdl/sdspi_seq.sv @@
module sdspi_seq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              step,
	input  sdspi_pkg::item_t  item,
	output sdspi_pkg::result_t res
);

	sdspi_pkg::phase_t               phase_q, phase_d;
	logic [sdspi_pkg::CNT_W-1:0]     bcnt_q, bcnt_d, bcnt_inc;
	logic [5:0]                      cmd_q, cmd_d;
	logic [31:0]                     arg_q, arg_d;
	logic [31:0]                     rsh_q, rsh_d, rsh_next;
	logic                            hc_q, hc_d;
	logic [1:0]                      v2_q, v2_d;
	logic [31:0]                     off_q, off_d;
	logic [31:0]                     rem_q, rem_d;
	logic [sdspi_pkg::CNT_W-1:0]     chunk_q, chunk_d;
	logic [sdspi_pkg::CNT_W-1:0]     lead;
	logic                            iss;
	logic [5:0]                      iss_idx;
	logic [31:0]                     iss_arg;
	logic                            txv, dv, done;
	logic [7:0]                      txb, db;

	function automatic logic [7:0] frame_byte(input logic [2:0] k, input logic [5:0] idx,
			input logic [31:0] arg);
		logic [7:0] b;
		unique case (k)
			3'd0: b = sdspi_pkg::CMD_PREFIX | {2'b00, idx};
			3'd1: b = arg[31:24];
			3'd2: b = arg[23:16];
			3'd3: b = arg[15:8];
			3'd4: b = arg[7:0];
			default: begin
				if (idx == sdspi_pkg::CMD_GO_IDLE)
					b = sdspi_pkg::CRC_CMD0;
				else if (idx == sdspi_pkg::CMD_SEND_IF_COND)
					b = sdspi_pkg::CRC_CMD8;
				else
					b = sdspi_pkg::CRC_OTHER;
			end
		endcase
		return b;
	endfunction

	function automatic logic [sdspi_pkg::CNT_W-1:0] chunk_of(input logic [31:0] off,
			input logic [31:0] rem);
		logic [sdspi_pkg::CNT_W-1:0] room;
		room = sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES)
			- sdspi_pkg::CNT_W'(off[sdspi_pkg::BLOCK_AW-1:0]);
		return (rem < 32'(room)) ? rem[sdspi_pkg::CNT_W-1:0] : room;
	endfunction

	function automatic logic [31:0] addr_of(input logic hc, input logic [31:0] off);
		logic [31:0] a;
		if (hc)
			a = off >> sdspi_pkg::BLOCK_AW;
		else
			a = off & ~(32'(sdspi_pkg::BLOCK_BYTES) - 32'd1);
		return a;
	endfunction

	assign lead = sdspi_pkg::CNT_W'(off_q[sdspi_pkg::BLOCK_AW-1:0]);
	assign bcnt_inc = bcnt_q + 1'b1;
	assign rsh_next = {rsh_q[23:0], item.rx_byte};

	always_comb begin
		phase_d = phase_q;
		bcnt_d = bcnt_q;
		cmd_d = cmd_q;
		arg_d = arg_q;
		rsh_d = rsh_q;
		hc_d = hc_q;
		v2_d = v2_q;
		off_d = off_q;
		rem_d = rem_q;
		chunk_d = chunk_q;
		iss = 1'b0;
		iss_idx = sdspi_pkg::CMD_APP;
		iss_arg = '0;
		txv = 1'b0;
		txb = '0;
		dv = 1'b0;
		db = '0;
		done = 1'b0;

		unique case (item.op)
			sdspi_pkg::OP_INIT: begin
				v2_d = '0;
				hc_d = 1'b0;
				phase_d = sdspi_pkg::PH_POWER;
				bcnt_d = sdspi_pkg::CNT_W'(1);
				txv = 1'b1;
				txb = sdspi_pkg::FILL_BYTE;
			end
			sdspi_pkg::OP_READ: begin
				off_d = '0;
				rem_d = 32'(sdspi_pkg::BLOCK_BYTES);
				chunk_d = sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES);
				iss = 1'b1;
				iss_idx = sdspi_pkg::CMD_READ_SINGLE;
				iss_arg = hc_q ? item.block_or_offset
					: (item.block_or_offset << sdspi_pkg::BLOCK_AW);
			end
			sdspi_pkg::OP_STREAM: begin
				off_d = item.block_or_offset;
				rem_d = item.byte_count;
				if (item.byte_count == '0) begin
					phase_d = sdspi_pkg::PH_IDLE;
					done = 1'b1;
				end else begin
					chunk_d = chunk_of(item.block_or_offset, item.byte_count);
					iss = 1'b1;
					iss_idx = sdspi_pkg::CMD_READ_SINGLE;
					iss_arg = addr_of(hc_q, item.block_or_offset);
				end
			end
			sdspi_pkg::OP_REPLY: begin
				unique case (phase_q)
					sdspi_pkg::PH_POWER: begin
						if (bcnt_q < sdspi_pkg::CNT_W'(sdspi_pkg::POWERUP_DUMMY_BYTES)) begin
							bcnt_d = bcnt_inc;
							txv = 1'b1;
							txb = sdspi_pkg::FILL_BYTE;
						end else begin
							cmd_d = sdspi_pkg::CMD_GO_IDLE;
							arg_d = '0;
							phase_d = sdspi_pkg::PH_COMMAND;
							bcnt_d = '0;
							txv = 1'b1;
							txb = frame_byte(3'd0, sdspi_pkg::CMD_GO_IDLE, '0);
						end
					end
					sdspi_pkg::PH_READY: begin
						txv = 1'b1;
						if (item.rx_byte != '0) begin
							phase_d = sdspi_pkg::PH_COMMAND;
							bcnt_d = '0;
							txb = frame_byte(3'd0, cmd_q, arg_q);
						end else begin
							txb = sdspi_pkg::FILL_BYTE;
						end
					end
					sdspi_pkg::PH_COMMAND: begin
						bcnt_d = bcnt_inc;
						txv = 1'b1;
						if (bcnt_inc < sdspi_pkg::CNT_W'(6)) begin
							txb = frame_byte(bcnt_inc[2:0], cmd_q, arg_q);
						end else begin
							phase_d = sdspi_pkg::PH_RESPONSE;
							txb = sdspi_pkg::FILL_BYTE;
						end
					end
					sdspi_pkg::PH_RESPONSE: begin
						if (item.rx_byte == sdspi_pkg::FILL_BYTE) begin
							txv = 1'b1;
							txb = sdspi_pkg::FILL_BYTE;
						end else if (cmd_q == sdspi_pkg::CMD_GO_IDLE) begin
							iss = 1'b1;
							iss_idx = sdspi_pkg::CMD_SEND_IF_COND;
							iss_arg = sdspi_pkg::ARG_CMD8;
						end else if (cmd_q == sdspi_pkg::CMD_SEND_IF_COND) begin
							if (item.rx_byte == 8'd1) begin
								v2_d[0] = 1'b1;
								phase_d = sdspi_pkg::PH_TAIL;
								bcnt_d = '0;
								rsh_d = '0;
								txv = 1'b1;
								txb = sdspi_pkg::FILL_BYTE;
							end else begin
								iss = 1'b1;
							end
						end else if (cmd_q == sdspi_pkg::CMD_APP) begin
							iss = 1'b1;
							iss_idx = sdspi_pkg::CMD_SD_SEND_OP;
							iss_arg = sdspi_pkg::ARG_ACMD41;
						end else if (cmd_q == sdspi_pkg::CMD_SD_SEND_OP) begin
							iss = 1'b1;
							if (item.rx_byte == '0)
								iss_idx = sdspi_pkg::CMD_READ_OCR;
						end else if (cmd_q == sdspi_pkg::CMD_READ_OCR) begin
							if (item.rx_byte == '0) begin
								phase_d = sdspi_pkg::PH_TAIL;
								bcnt_d = '0;
								rsh_d = '0;
								txv = 1'b1;
								txb = sdspi_pkg::FILL_BYTE;
							end else begin
								phase_d = sdspi_pkg::PH_IDLE;
								done = 1'b1;
							end
						end else begin
							phase_d = sdspi_pkg::PH_TOKEN;
							txv = 1'b1;
							txb = sdspi_pkg::FILL_BYTE;
						end
					end
					sdspi_pkg::PH_TAIL: begin
						rsh_d = rsh_next;
						bcnt_d = bcnt_inc;
						if (bcnt_inc < sdspi_pkg::CNT_W'(4)) begin
							txv = 1'b1;
							txb = sdspi_pkg::FILL_BYTE;
						end else if (cmd_q == sdspi_pkg::CMD_SEND_IF_COND) begin
							if (rsh_next[11:0] == sdspi_pkg::CHECK_PATTERN)
								v2_d[1] = 1'b1;
							iss = 1'b1;
						end else begin
							if (rsh_next[sdspi_pkg::OCR_CCS_BIT])
								hc_d = 1'b1;
							phase_d = sdspi_pkg::PH_IDLE;
							done = 1'b1;
						end
					end
					sdspi_pkg::PH_TOKEN: begin
						if (item.rx_byte == sdspi_pkg::START_TOKEN) begin
							phase_d = sdspi_pkg::PH_DATA;
							bcnt_d = '0;
						end
						txv = 1'b1;
						txb = sdspi_pkg::FILL_BYTE;
					end
					sdspi_pkg::PH_DATA: begin
						if (bcnt_q >= lead && (bcnt_q - lead) < chunk_q) begin
							dv = 1'b1;
							db = item.rx_byte;
						end
						if (bcnt_inc >= sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES)) begin
							phase_d = sdspi_pkg::PH_CRC;
							bcnt_d = '0;
						end else begin
							bcnt_d = bcnt_inc;
						end
						txv = 1'b1;
						txb = sdspi_pkg::FILL_BYTE;
					end
					sdspi_pkg::PH_CRC: begin
						bcnt_d = bcnt_inc;
						if (bcnt_inc < sdspi_pkg::CNT_W'(2)) begin
							rem_d = rem_q - 32'(chunk_q);
							off_d = off_q + 32'(chunk_q);
							txv = 1'b1;
							txb = sdspi_pkg::FILL_BYTE;
						end else if (rem_q != '0) begin
							chunk_d = chunk_of(off_q, rem_q);
							iss = 1'b1;
							iss_idx = sdspi_pkg::CMD_READ_SINGLE;
							iss_arg = addr_of(hc_q, off_q);
						end else begin
							phase_d = sdspi_pkg::PH_IDLE;
							done = 1'b1;
						end
					end
					default: begin
						phase_d = sdspi_pkg::PH_IDLE;
					end
				endcase
			end
			default: begin
				phase_d = phase_q;
			end
		endcase

		if (iss) begin
			cmd_d = iss_idx;
			arg_d = iss_arg;
			phase_d = sdspi_pkg::PH_READY;
			txv = 1'b1;
			txb = sdspi_pkg::FILL_BYTE;
		end

		res.tx_valid = txv;
		res.tx_byte = txb;
		res.select_high = (phase_d == sdspi_pkg::PH_POWER);
		res.data_valid = dv;
		res.data_byte = db;
		res.busy = (phase_d != sdspi_pkg::PH_IDLE);
		res.done = done;
		res.high_capacity = hc_d;
		res.v2_card = v2_d[0];
		res.voltage_ok = v2_d[1];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= sdspi_pkg::PH_IDLE;
			bcnt_q <= '0;
			cmd_q <= '0;
			arg_q <= '0;
			rsh_q <= '0;
			hc_q <= 1'b0;
			v2_q <= '0;
			off_q <= '0;
			rem_q <= '0;
			chunk_q <= '0;
		end else if (step) begin
			phase_q <= phase_d;
			bcnt_q <= bcnt_d;
			cmd_q <= cmd_d;
			arg_q <= arg_d;
			rsh_q <= rsh_d;
			hc_q <= hc_d;
			v2_q <= v2_d;
			off_q <= off_d;
			rem_q <= rem_d;
			chunk_q <= chunk_d;
		end
	end

	a_data_in_window: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sdspi_pkg::PH_DATA |-> bcnt_q < sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES))
		else $error("data byte counter past block end");
	a_chunk_bound: assert property (@(posedge clk) disable iff (!arst_n)
		phase_q == sdspi_pkg::PH_DATA
			|-> chunk_q <= sdspi_pkg::CNT_W'(sdspi_pkg::BLOCK_BYTES) - lead)
		else $error("chunk runs past block end");
	a_idle_holds: assert property (@(posedge clk) disable iff (!arst_n)
		step && phase_q == sdspi_pkg::PH_IDLE && item.op == sdspi_pkg::OP_REPLY
			|=> phase_q == sdspi_pkg::PH_IDLE)
		else $error("stray reply left idle");

endmodule

@@ hdl/sd_spi_init_and_block_read_core.sv @@
// SD card host sequencer for SPI mode, one card byte exchange per item.
// Input channel (in_valid / in_stall) carries op, block_or_offset, byte_count
// and rx_byte. Op 0 starts init, op 1 reads one block, op 2 streams byte_count
// bytes from a byte offset, op 3 returns the byte the card sent in the last
// exchange. Every accepted item yields exactly one result beat on the output
// channel (out_valid / out_stall): when tx_valid is set, shift tx_byte out at
// the select_high level and send the card's reply back as the next op 3 item.
// data_valid marks a wanted payload byte in data_byte.
// The item is registered in the input register, then its result in the result
// register; one item is accepted every cycle while in_stall stays low.
// The next state is formed in the same cycle from the registered item and
// the current sequencer state.
// Reset clears the sequencer to idle with all card flags low; both channels
// come up empty. While out_stall is high the result register holds its beat
// and the input register holds one more item; in_stall rises only when both
// are full.
module sd_spi_init_and_block_read_core (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [1:0]  op,
	input  logic [31:0] block_or_offset,
	input  logic [31:0] byte_count,
	input  logic [7:0]  rx_byte,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        tx_valid,
	output logic [7:0]  tx_byte,
	output logic        select_high,
	output logic        data_valid,
	output logic [7:0]  data_byte,
	output logic        busy_res,
	output logic        done_res,
	output logic        high_capacity,
	output logic        v2_card,
	output logic        voltage_ok
);

	logic                valid_s1;
	sdspi_pkg::item_t    item_s1;
	logic                out_valid_q;
	sdspi_pkg::result_t  res_q;
	sdspi_pkg::result_t  res_d;
	logic                advance;

	assign advance = valid_s1 && !(out_valid_q && out_stall);
	assign in_stall = valid_s1 && !advance;

	sdspi_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.step   (advance),
		.item   (item_s1),
		.res    (res_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (!in_stall)
				valid_s1 <= in_valid;
			if (advance)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (!in_stall && in_valid) begin
			item_s1.op <= sdspi_pkg::op_t'(op);
			item_s1.block_or_offset <= block_or_offset;
			item_s1.byte_count <= byte_count;
			item_s1.rx_byte <= rx_byte;
		end
		if (advance)
			res_q <= res_d;
	end

	assign out_valid = out_valid_q;
	assign tx_valid = res_q.tx_valid;
	assign tx_byte = res_q.tx_byte;
	assign select_high = res_q.select_high;
	assign data_valid = res_q.data_valid;
	assign data_byte = res_q.data_byte;
	assign busy_res = res_q.busy;
	assign done_res = res_q.done;
	assign high_capacity = res_q.high_capacity;
	assign v2_card = res_q.v2_card;
	assign voltage_ok = res_q.voltage_ok;

	a_done_not_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(res_q.done && res_q.busy))
		else $error("done and busy in one beat");
	a_tx_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.tx_valid |-> res_q.busy)
		else $error("exchange requested while idle");
	a_data_fill: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.data_valid
			|-> res_q.tx_valid && res_q.tx_byte == sdspi_pkg::FILL_BYTE)
		else $error("payload beat without fill request");
	a_select_power: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && res_q.select_high
			|-> res_q.tx_valid && res_q.tx_byte == sdspi_pkg::FILL_BYTE && !res_q.data_valid)
		else $error("deselected beat is not a fill byte");

endmodule

@@ dv/tb.sv @@
`timescale 1ns / 100ps

module tb;
	import sdspi_pkg::*;

	localparam logic [7:0] R1_READY = 8'h00;
	localparam logic [7:0] R1_IDLE = 8'h01;
	localparam logic [7:0] R1_ILLEGAL = 8'h05;
	localparam int RANDOM_STEPS = 1650;

	typedef struct {
		op_t         o;
		logic [31:0] a;
		logic [31:0] c;
		logic [7:0]  rx;
		bit          typed;
		result_t     want;
	} plan_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic [1:0]  op = '0;
	logic [31:0] block_or_offset = '0;
	logic [31:0] byte_count = '0;
	logic [7:0]  rx_byte = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        tx_valid;
	logic [7:0]  tx_byte;
	logic        select_high;
	logic        data_valid;
	logic [7:0]  data_byte;
	logic        busy_res;
	logic        done_res;
	logic        high_capacity;
	logic        v2_card;
	logic        voltage_ok;

	logic        hold_rx = 1'b0;

	phase_t      ph = PH_IDLE;
	logic [9:0]  ph_cnt = '0;
	logic [5:0]  cmd_idx = '0;
	logic [31:0] cmd_arg = '0;
	logic [31:0] reply_acc = '0;
	logic        card_hc = 1'b0;
	logic [1:0]  card_flags = '0;
	logic [31:0] strm_off = '0;
	logic [31:0] strm_left = '0;
	logic [9:0]  chunk_len = '0;
	result_t     step_res;

	result_t     due_steps[$];
	plan_row_t   plan[$];
	int          mismatches = 0;
	int          beats_checked = 0;
	int          items_sent = 0;
	int          run_len = 0;
	int          n_inits = 0;
	int          n_reads = 0;
	int          n_streams = 0;
	int          payload_bytes = 0;
	bit          tx_idle_on = 1'b1;

	sd_spi_init_and_block_read_core dut (.*);

	always #5 clk = ~clk;

	function automatic result_t quick_res(bit txv, logic [7:0] tx, bit sel, bit busy, bit done);
		result_t r;
		r = '0;
		r.tx_valid = txv;
		r.tx_byte = tx;
		r.select_high = sel;
		r.busy = busy;
		r.done = done;
		return r;
	endfunction

	function automatic string fmt_res(result_t x);
		return $sformatf("tx %b/%h sel %b data %b/%h busy %b done %b hc %b v2 %b vok %b",
			x.tx_valid, x.tx_byte, x.select_high, x.data_valid, x.data_byte, x.busy,
			x.done, x.high_capacity, x.v2_card, x.voltage_ok);
	endfunction

	function automatic void emit(logic [7:0] b);
		step_res.tx_valid = 1'b1;
		step_res.tx_byte = b;
	endfunction

	function automatic void end_sequence();
		ph = PH_IDLE;
		step_res.done = 1'b1;
	endfunction

	function automatic logic [7:0] frame_byte(logic [9:0] k);
		if (k == 0)
			return CMD_PREFIX | {2'b00, cmd_idx};
		if (k <= 4)
			return 8'(cmd_arg >> (8 * (4 - int'(k))));
		if (cmd_idx == CMD_GO_IDLE)
			return CRC_CMD0;
		if (cmd_idx == CMD_SEND_IF_COND)
			return CRC_CMD8;
		return CRC_OTHER;
	endfunction

	function automatic void issue_cmd(logic [5:0] idx, logic [31:0] arg);
		cmd_idx = idx;
		cmd_arg = arg;
		if (idx != CMD_GO_IDLE) begin
			ph = PH_READY;
			emit(FILL_BYTE);
		end else begin
			ph = PH_COMMAND;
			ph_cnt = '0;
			emit(frame_byte('0));
		end
	endfunction

	function automatic logic [31:0] blk_addr();
		return card_hc ? (strm_off >> BLOCK_AW) : (strm_off & ~32'(BLOCK_BYTES - 1));
	endfunction

	function automatic void begin_chunk(logic [31:0] addr);
		logic [31:0] room;
		room = BLOCK_BYTES - strm_off[BLOCK_AW-1:0];
		chunk_len = (strm_left < room) ? strm_left[9:0] : room[9:0];
		issue_cmd(CMD_READ_SINGLE, addr);
	endfunction

	function automatic void start_tail();
		ph = PH_TAIL;
		ph_cnt = '0;
		reply_acc = '0;
		emit(FILL_BYTE);
	endfunction

	function automatic void take_reply(logic [7:0] rx);
		logic [9:0] lead;
		case (ph)
			PH_POWER: begin
				if (ph_cnt < POWERUP_DUMMY_BYTES) begin
					ph_cnt++;
					emit(FILL_BYTE);
				end else
					issue_cmd(CMD_GO_IDLE, '0);
			end
			PH_READY: begin
				if (rx != 8'h00) begin
					ph = PH_COMMAND;
					ph_cnt = '0;
					emit(frame_byte('0));
				end else
					emit(FILL_BYTE);
			end
			PH_COMMAND: begin
				ph_cnt++;
				if (ph_cnt < 6)
					emit(frame_byte(ph_cnt));
				else begin
					ph = PH_RESPONSE;
					emit(FILL_BYTE);
				end
			end
			PH_RESPONSE: begin
				if (rx == FILL_BYTE)
					emit(FILL_BYTE);
				else begin
					case (cmd_idx)
						CMD_GO_IDLE: issue_cmd(CMD_SEND_IF_COND, ARG_CMD8);
						CMD_SEND_IF_COND: begin
							if (rx == R1_IDLE) begin
								card_flags[0] = 1'b1;
								start_tail();
							end else
								issue_cmd(CMD_APP, '0);
						end
						CMD_APP: issue_cmd(CMD_SD_SEND_OP, ARG_ACMD41);
						CMD_SD_SEND_OP: begin
							if (rx == R1_READY)
								issue_cmd(CMD_READ_OCR, '0);
							else
								issue_cmd(CMD_APP, '0);
						end
						CMD_READ_OCR: begin
							if (rx == R1_READY)
								start_tail();
							else
								end_sequence();
						end
						default: begin
							ph = PH_TOKEN;
							emit(FILL_BYTE);
						end
					endcase
				end
			end
			PH_TAIL: begin
				reply_acc = {reply_acc[23:0], rx};
				ph_cnt++;
				if (ph_cnt < 4)
					emit(FILL_BYTE);
				else if (cmd_idx == CMD_SEND_IF_COND) begin
					if (reply_acc[11:0] == CHECK_PATTERN)
						card_flags[1] = 1'b1;
					issue_cmd(CMD_APP, '0);
				end else begin
					if (reply_acc[OCR_CCS_BIT])
						card_hc = 1'b1;
					end_sequence();
				end
			end
			PH_TOKEN: begin
				if (rx == START_TOKEN) begin
					ph = PH_DATA;
					ph_cnt = '0;
				end
				emit(FILL_BYTE);
			end
			PH_DATA: begin
				lead = {1'b0, strm_off[BLOCK_AW-1:0]};
				if (ph_cnt >= lead && ph_cnt - lead < chunk_len) begin
					step_res.data_valid = 1'b1;
					step_res.data_byte = rx;
				end
				ph_cnt++;
				if (ph_cnt >= BLOCK_BYTES) begin
					ph = PH_CRC;
					ph_cnt = '0;
				end
				emit(FILL_BYTE);
			end
			PH_CRC: begin
				ph_cnt++;
				if (ph_cnt < 2)
					emit(FILL_BYTE);
				else begin
					strm_left -= chunk_len;
					strm_off += chunk_len;
					if (strm_left != 0)
						begin_chunk(blk_addr());
					else
						end_sequence();
				end
			end
			default: ph = PH_IDLE;
		endcase
	endfunction

	function automatic result_t sd_host_step(op_t o, logic [31:0] a, logic [31:0] c,
			logic [7:0] rx);
		step_res = '0;
		case (o)
			OP_INIT: begin
				card_flags = '0;
				card_hc = 1'b0;
				ph = PH_POWER;
				ph_cnt = 10'd1;
				emit(FILL_BYTE);
			end
			OP_READ: begin
				strm_off = '0;
				strm_left = BLOCK_BYTES;
				begin_chunk(card_hc ? a : (a << BLOCK_AW));
			end
			OP_STREAM: begin
				strm_off = a;
				strm_left = c;
				if (c == 0)
					end_sequence();
				else
					begin_chunk(blk_addr());
			end
			default: begin
				if (ph != PH_IDLE)
					take_reply(rx);
			end
		endcase
		step_res.select_high = (ph == PH_POWER);
		step_res.busy = (ph != PH_IDLE);
		step_res.high_capacity = card_hc;
		step_res.v2_card = card_flags[0];
		step_res.voltage_ok = card_flags[1];
		return step_res;
	endfunction

	// card side: mostly well-formed replies, some noise bytes and aborts
	task automatic pick_item(output op_t o, output logic [31:0] a, output logic [31:0] c,
			output logic [7:0] r);
		int roll;
		roll = $urandom_range(0, 9999);
		o = OP_REPLY;
		a = $urandom;
		c = $urandom;
		r = $urandom;
		if (ph == PH_IDLE || run_len > 1400 || roll < ((ph == PH_DATA) ? 5 : 100)) begin
			run_len = 0;
			roll = $urandom_range(0, 99);
			if (roll < 30)
				o = OP_INIT;
			else if (roll < 45)
				o = OP_READ;
			else begin
				o = OP_STREAM;
				roll = $urandom_range(0, 19);
				if (roll == 0)
					c = '0;
				else if (roll > 1)
					c = $urandom_range(1, 700);
			end
			return;
		end
		run_len++;
		if (roll >= 9700)
			return;
		case (ph)
			PH_READY: r = ($urandom_range(0, 4) == 0) ? 8'h00 : FILL_BYTE;
			PH_RESPONSE: begin
				if ($urandom_range(0, 2) == 0)
					r = FILL_BYTE;
				else begin
					case (cmd_idx)
						CMD_SEND_IF_COND:
							r = ($urandom_range(0, 4) == 0) ? R1_ILLEGAL : R1_IDLE;
						CMD_SD_SEND_OP: r = ($urandom_range(0, 1) == 0) ? R1_IDLE : R1_READY;
						CMD_READ_OCR: r = ($urandom_range(0, 9) == 0) ? R1_ILLEGAL : R1_READY;
						CMD_READ_SINGLE: r = R1_READY;
						default: r = R1_IDLE;
					endcase
				end
			end
			PH_TAIL: begin
				if (cmd_idx == CMD_SEND_IF_COND) begin
					if ($urandom_range(0, 9) != 0)
						r = 8'(ARG_CMD8 >> (8 * (3 - int'(ph_cnt))));
				end else if (ph_cnt == 0)
					r = {1'b1, 1'($urandom_range(0, 1)), 6'b0};
			end
			PH_TOKEN: r = ($urandom_range(0, 2) == 0) ? FILL_BYTE : START_TOKEN;
			default: ;
		endcase
	endtask

	task automatic drive_item(op_t o, logic [31:0] a, logic [31:0] c, logic [7:0] r,
			bit typed, result_t want);
		int gap;
		result_t p;
		gap = tx_idle_on ? $urandom_range(0, 9) : 0;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		op <= o;
		block_or_offset <= a;
		byte_count <= c;
		rx_byte <= r;
		do @(posedge clk); while (in_stall);
		case (o)
			OP_INIT: n_inits++;
			OP_READ: n_reads++;
			OP_STREAM: n_streams++;
			default: ;
		endcase
		p = sd_host_step(o, a, c, r);
		if (p.data_valid)
			payload_bytes++;
		due_steps.push_back(typed ? want : p);
		items_sent++;
	endtask

	task automatic flag_beat(string why, result_t want, result_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$display("%0t: %s", $realtime, why);
			$display("  exp %s", fmt_res(want));
			$display("  got %s", fmt_res(got));
		end
	endtask

	always @(posedge clk) begin
		result_t got;
		result_t want;
		int rx_pause_left;
		bit rx_idle_on;
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				got = {tx_valid, tx_byte, select_high, data_valid, data_byte, busy_res,
					done_res, high_capacity, v2_card, voltage_ok};
				if (due_steps.size() == 0)
					flag_beat("beat with nothing expected", '0, got);
				else begin
					want = due_steps.pop_front();
					if (got !== want)
						flag_beat("beat mismatch", want, got);
				end
				beats_checked++;
				if (beats_checked % 80 == 0)
					rx_idle_on = ($urandom_range(0, 3) != 0);
				rx_pause_left = rx_idle_on ? $urandom_range(0, 9) : 0;
			end
			if (hold_rx || rx_pause_left > 0) begin
				out_stall <= 1'b1;
				if (rx_pause_left > 0)
					rx_pause_left--;
			end else
				out_stall <= 1'b0;
		end
	end

	// hold off the receiver while the sender keeps offering beats
	initial begin
		wait (items_sent >= 400);
		@(posedge clk);
		hold_rx <= 1'b1;
		repeat (300) @(posedge clk);
		hold_rx <= 1'b0;
	end

	initial begin
		#3_000_000;
		$display("Some tests failed");
		$finish;
	end

	initial begin
		op_t o;
		logic [31:0] a;
		logic [31:0] c;
		logic [7:0] r;
		int random_items;
		random_items = 0;
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hA5, 1'b1, quick_res(0, 8'h00, 0, 0, 0)});
		plan.push_back('{OP_STREAM, 32'h0, 32'h0, 8'h00, 1'b1, quick_res(0, 8'h00, 0, 0, 1)});
		plan.push_back('{OP_READ, 32'hFFFF_FFFF, 32'h0, 8'h00, 1'b1,
			quick_res(1, FILL_BYTE, 0, 1, 0)});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'h00, 1'b1, quick_res(1, FILL_BYTE, 0, 1, 0)});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'h00, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'h00, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, R1_READY, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, START_TOKEN, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_STREAM, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b0, '0});
		plan.push_back('{OP_INIT, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'hFF, 1'b1,
			quick_res(1, FILL_BYTE, 1, 1, 0)});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'h00, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'h5A, 1'b0, '0});
		plan.push_back('{OP_REPLY, 32'h0, 32'h0, 8'hFF, 1'b0, '0});

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (plan[i])
			drive_item(plan[i].o, plan[i].a, plan[i].c, plan[i].rx, plan[i].typed, plan[i].want);

		while (random_items < RANDOM_STEPS) begin
			if (random_items % 64 == 0)
				tx_idle_on = ($urandom_range(0, 3) != 0);
			pick_item(o, a, c, r);
			drive_item(o, a, c, r, 1'b0, '0);
			random_items++;
			if (random_items == 900) begin
				in_valid <= 1'b0;
				while (due_steps.size() != 0) @(posedge clk);
			end
		end
		in_valid <= 1'b0;

		while (due_steps.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("Checked %0d exchange beats: %0d inits, %0d block reads, %0d streams started.",
			beats_checked, n_inits, n_reads, n_streams);
		$display("Payload bytes predicted: %0d, mismatches: %0d.", payload_bytes, mismatches);
		if (mismatches == 0 && due_steps.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

endmodule
